### hw/rtl/rfr_pkg.sv
// Register frame receiver: shared constants and codes.
// No dependencies.
package rfr_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 40;
  localparam int unsigned DATA_BYTES_DEF   = 32;

  localparam int unsigned HEADER_BYTES   = 6;
  localparam int unsigned OVERHEAD_BYTES = 8;

  localparam logic [7:0] TIMEOUT_RESET = 8'd5;
  localparam logic [7:0] IDLE_MAX      = 8'd255;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ERROR    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // byte positions of the header fields inside a frame
  localparam int unsigned IDX_SRC    = 0;
  localparam int unsigned IDX_DST    = 1;
  localparam int unsigned IDX_FUNC   = 2;
  localparam int unsigned IDX_RID_HI = 3;
  localparam int unsigned IDX_RID_LO = 4;
  localparam int unsigned IDX_LEN    = 5;

endpackage

### hw/rtl/register_frame_receiver_unit.sv
// Register frame receiver top level: byte/tick intake, frame check, readout.
// A status or empty-frame result is registered; the first data byte passes S_RD and S_LD first.
// Throughput: one input transfer per cycle unless a frame is read out or a result waits;
// a good frame reads its data bytes from the frame store one at a time, via S_RD and S_LD.
// Reset (async, active low): empty frame, idle count 0, timeout 5 ticks.
// Depends on rfr_pkg and rfr_frame_mem.
module register_frame_receiver_unit import rfr_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int unsigned DATA_BYTES   = DATA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  source_address_o,
  output logic [7:0]  destination_address_o,
  output logic [7:0]  function_code_o,
  output logic [15:0] register_id_o,
  output logic [5:0]  data_length_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned CW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned KW = $clog2(DATA_BYTES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] bc_q, bc_d;
  logic [7:0]    idle_q, idle_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    tmo_q;
  logic [KW-1:0] k_q, k_d;

  logic [7:0] src_q, dst_q, func_q, rid_hi_q, rid_lo_q, len_q, prev_q;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [7:0]  src_out_q, dst_out_q, func_out_q, data_out_q;
  logic [15:0] rid_out_q;
  logic [5:0]  len_out_q;
  logic        last_out_q;

  logic          acc, byte_acc, out_free;
  logic [CW-1:0] bc_inc;
  logic [8:0]    n9, need9;
  logic [7:0]    idle_inc;
  logic [15:0]   got, want;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic       ld, ld_hdr, ld_last;
  logic [1:0] ld_status;
  logic [7:0] ld_data;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign byte_acc   = acc && (op_i == OP_BYTE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign bc_inc   = bc_q + CW'(1);
  assign n9       = 9'(bc_q) + 9'd1;
  assign need9    = 9'(OVERHEAD_BYTES) + {1'b0, len_q};
  assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 8'd1;
  assign got      = sum_q - {8'd0, prev_q};
  assign want     = {prev_q, rx_byte_i};
  assign mem_raddr = AW'(HEADER_BYTES) + AW'(k_q);

  rfr_frame_mem #(
    .DEPTH (PACKET_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (bc_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    bc_d      = bc_q;
    idle_d    = idle_q;
    sum_d     = sum_q;
    k_d       = k_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    ld        = 1'b0;
    ld_hdr    = 1'b0;
    ld_last   = 1'b1;
    ld_status = ST_OK;
    ld_data   = 8'd0;
    case (state_q)
      S_IDLE: begin
        if (acc && op_i == OP_TICK) begin
          idle_d = idle_inc;
          if (idle_inc >= tmo_q && bc_q != '0) begin
            bc_d      = '0;
            sum_d     = 16'd0;
            ld        = 1'b1;
            ld_status = ST_TIMEOUT;
          end
        end else if (byte_acc) begin
          idle_d = 8'd0;
          mem_we = 1'b1;
          bc_d   = bc_inc;
          sum_d  = sum_q + {8'd0, rx_byte_i};
          if (bc_inc == CW'(PACKET_BYTES)) begin
            bc_d      = '0;
            sum_d     = 16'd0;
            ld        = 1'b1;
            ld_status = ST_OVERFLOW;
          end else if (n9 >= 9'(OVERHEAD_BYTES) && n9 >= need9) begin
            bc_d  = '0;
            sum_d = 16'd0;
            if (len_q > 8'(DATA_BYTES) || got != want) begin
              ld        = 1'b1;
              ld_status = ST_ERROR;
            end else if (len_q == 8'd0) begin
              ld     = 1'b1;
              ld_hdr = 1'b1;
            end else begin
              k_d     = '0;
              state_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_hdr  = 1'b1;
          ld_data = mem_rdata;
          ld_last = (8'(k_q) + 8'd1 == len_q);
          if (ld_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bc_q        <= '0;
      idle_q      <= 8'd0;
      sum_q       <= 16'd0;
      k_q         <= '0;
      tmo_q       <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bc_q        <= bc_d;
      idle_q      <= idle_d;
      sum_q       <= sum_d;
      k_q         <= k_d;
      out_valid_q <= ld || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
    end
  end

  // header bytes are also kept in flops for the result fields
  always_ff @(posedge clk_i) begin
    if (byte_acc) begin
      prev_q <= rx_byte_i;
      if (bc_q == CW'(IDX_SRC)) begin
        src_q <= rx_byte_i;
      end
      if (bc_q == CW'(IDX_DST)) begin
        dst_q <= rx_byte_i;
      end
      if (bc_q == CW'(IDX_FUNC)) begin
        func_q <= rx_byte_i;
      end
      if (bc_q == CW'(IDX_RID_HI)) begin
        rid_hi_q <= rx_byte_i;
      end
      if (bc_q == CW'(IDX_RID_LO)) begin
        rid_lo_q <= rx_byte_i;
      end
      if (bc_q == CW'(IDX_LEN)) begin
        len_q <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      status_q   <= ld_status;
      src_out_q  <= ld_hdr ? src_q : 8'd0;
      dst_out_q  <= ld_hdr ? dst_q : 8'd0;
      func_out_q <= ld_hdr ? func_q : 8'd0;
      rid_out_q  <= ld_hdr ? {rid_hi_q, rid_lo_q} : 16'd0;
      len_out_q  <= ld_hdr ? len_q[5:0] : 6'd0;
      data_out_q <= ld_data;
      last_out_q <= ld_last;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign source_address_o      = src_out_q;
  assign destination_address_o = dst_out_q;
  assign function_code_o       = func_out_q;
  assign register_id_o         = rid_out_q;
  assign data_length_o         = len_out_q;
  assign data_byte_o           = data_out_q;
  assign last_o                = last_out_q;

`ifndef ASSERT_OFF
  a_bc_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q < CW'(PACKET_BYTES))
    else $error("byte count reached store depth");

  a_readout_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_LD) |->
      (len_q != 8'd0 && len_q <= 8'(DATA_BYTES) && 8'(k_q) < len_q))
    else $error("readout index outside frame data");

  a_overflow_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_acc && bc_inc == CW'(PACKET_BYTES)) |=>
      (bc_q == '0 && out_valid_q && status_q == ST_OVERFLOW && last_out_q))
    else $error("overflow not reported");

  a_no_load_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> out_free)
    else $error("result register overwritten");

  a_readout_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !acc)
    else $error("input transfer during readout");
`endif

endmodule

### hw/rtl/rfr_frame_mem.sv
// Frame store: single write port, single read port, registered read data.
// No package dependencies.
module rfr_frame_mem #(
  parameter int unsigned DEPTH = 40,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/rfr_frame_checker.sv
// Checker for register_frame_receiver_unit: mirrors the frame logic on every
// input transfer and compares each result transfer, in order, field by field.
// Depends on rfr_pkg.
module rfr_frame_checker import rfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  source_address_i,
  input  logic [7:0]  destination_address_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] register_id_i,
  input  logic [5:0]  data_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned STORE_DEPTH = PACKET_BYTES_DEF;
  localparam int unsigned MAX_DATA    = DATA_BYTES_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  func;
    logic [15:0] reg_id;
    logic [5:0]  len;
    logic [7:0]  data;
    logic        last;
  } frame_result_t;

  frame_result_t expected_results[$];
  logic [7:0]    rx_store [STORE_DEPTH];
  int unsigned   held_bytes;
  logic [7:0]    idle_ticks;
  logic [15:0]   byte_sum;
  logic [7:0]    timeout_reg;
  int            fails;

  function automatic frame_result_t status_only(logic [1:0] st);
    frame_result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic absorb_rx_item(input logic op, input logic [7:0] b);
    int unsigned len;
    int unsigned cnt;
    logic [15:0] want;
    logic [15:0] got;
    frame_result_t r;
    if (op == OP_TICK) begin
      if (idle_ticks != IDLE_MAX) idle_ticks++;
      if (idle_ticks >= timeout_reg && held_bytes > 0) begin
        held_bytes = 0;
        byte_sum = '0;
        expected_results.push_back(status_only(ST_TIMEOUT));
      end
    end else begin
      idle_ticks = '0;
      if (held_bytes < STORE_DEPTH) rx_store[held_bytes] = b;
      held_bytes++;
      byte_sum = byte_sum + b;
      if (held_bytes >= STORE_DEPTH) begin
        held_bytes = 0;
        byte_sum = '0;
        expected_results.push_back(status_only(ST_OVERFLOW));
      end else if (held_bytes >= OVERHEAD_BYTES) begin
        len = rx_store[IDX_LEN];
        if (held_bytes >= OVERHEAD_BYTES + len) begin
          want = {rx_store[held_bytes - 2], rx_store[held_bytes - 1]};
          got = byte_sum - rx_store[held_bytes - 2] - rx_store[held_bytes - 1];
          if (len > MAX_DATA || got != want) begin
            expected_results.push_back(status_only(ST_ERROR));
          end else begin
            cnt = (len == 0) ? 1 : len;
            for (int k = 0; k < cnt; k++) begin
              r.status = ST_OK;
              r.src    = rx_store[IDX_SRC];
              r.dst    = rx_store[IDX_DST];
              r.func   = rx_store[IDX_FUNC];
              r.reg_id = {rx_store[IDX_RID_HI], rx_store[IDX_RID_LO]};
              r.len    = 6'(len);
              r.data   = (len == 0) ? 8'd0 : rx_store[HEADER_BYTES + k];
              r.last   = (k == cnt - 1);
              expected_results.push_back(r);
            end
          end
          held_bytes = 0;
          byte_sum = '0;
        end
      end
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fails++;
    end
  endtask

  task automatic compare_result();
    frame_result_t want_r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, actual status %0d",
               $time, status_i);
      fails++;
    end else begin
      want_r = expected_results.pop_front();
      check_field("status", want_r.status, status_i);
      check_field("source_address", want_r.src, source_address_i);
      check_field("destination_address", want_r.dst, destination_address_i);
      check_field("function_code", want_r.func, function_code_i);
      check_field("register_id", want_r.reg_id, register_id_i);
      check_field("data_length", want_r.len, data_length_i);
      check_field("data_byte", want_r.data, data_byte_i);
      check_field("last", want_r.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      held_bytes = 0;
      idle_ticks = '0;
      byte_sum = '0;
      timeout_reg = TIMEOUT_RESET;
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) timeout_reg = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) absorb_rx_item(op_i, rx_byte_i);
      fail_count_o <= fails;
      pending_o <= expected_results.size();
    end
  end

endmodule

### verif/tb.sv
// Testbench top for register_frame_receiver_unit: clock, reset, byte and tick
// stimulus, result-side stalls, timeout register phases, watchdog and verdict.
// Depends on rfr_pkg, register_frame_receiver_unit and rfr_frame_checker.
module tb import rfr_pkg::*;;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_BYTE;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  source_address_o;
  logic [7:0]  destination_address_o;
  logic [7:0]  function_code_o;
  logic [15:0] register_id_o;
  logic [5:0]  data_length_o;
  logic [7:0]  data_byte_o;
  logic        last_o;

  int          fail_count;
  int          pending_count;
  int unsigned cur_timeout = TIMEOUT_RESET;
  bit          calm = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;
  int          items_sent = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          phase_start;
  int          kind;
  logic [7:0]  timeout_plan [5];

  register_frame_receiver_unit u_top (.*);

  rfr_frame_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .op_i                  (op_i),
    .rx_byte_i             (rx_byte_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_i              (status_o),
    .source_address_i      (source_address_o),
    .destination_address_i (destination_address_o),
    .function_code_i       (function_code_o),
    .register_id_i         (register_id_o),
    .data_length_i         (data_length_o),
    .data_byte_i           (data_byte_o),
    .last_i                (last_o),
    .fail_count_o          (fail_count),
    .pending_o             (pending_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (out_valid_o && !out_stall_i) results_seen <= results_seen + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off in the middle of a readout
  always begin
    @(posedge clk_i);
    if (squeeze_req && !squeeze_done && out_valid_o && !last_o) begin
      squeeze_done = 1'b1;
      out_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
    end
    out_stall_i <= !calm && ($urandom_range(99, 0) < 38);
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(99, 0) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_BYTE) bytes_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic flush_frame();
    send_ticks((cur_timeout == 0) ? 1 : cur_timeout);
  endtask

  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] func, input logic [15:0] rid,
                            input logic [7:0] len, input bit bad_sum,
                            input int unsigned cut, input bit ticks_inside);
    logic [7:0]  frame_q[$];
    logic [15:0] sum;
    frame_q.push_back(src);
    frame_q.push_back(dst);
    frame_q.push_back(func);
    frame_q.push_back(rid[15:8]);
    frame_q.push_back(rid[7:0]);
    frame_q.push_back(len);
    for (int k = 0; k < len; k++) frame_q.push_back(8'($urandom));
    sum = '0;
    foreach (frame_q[k]) sum = sum + frame_q[k];
    if (bad_sum) sum = sum ^ 16'($urandom_range(65535, 1));
    frame_q.push_back(sum[15:8]);
    frame_q.push_back(sum[7:0]);
    foreach (frame_q[k]) begin
      if (k < cut) begin
        if (ticks_inside && k > 0 && cur_timeout > 1 && $urandom_range(99, 0) < 20) begin
          send_ticks($urandom_range((cur_timeout > 4) ? 3 : cur_timeout - 1, 1));
        end
        send_item(OP_BYTE, frame_q[k]);
      end
    end
  endtask

  task automatic send_random_frame(input logic [7:0] len, input bit bad_sum,
                                   input int unsigned cut, input bit ticks_inside);
    send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
               len, bad_sum, cut, ticks_inside);
  endtask

  function automatic logic [7:0] pick_len();
    return ($urandom_range(99, 0) < 70) ? 8'($urandom_range(6, 0))
                                        : 8'($urandom_range(DATA_BYTES_DEF - 1, 7));
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_timeout = value;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty frame with all-ones header, one-byte frame with zero header and bad sum, stale frame
    send_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'd0, 1'b0, 99, 1'b0);
    send_frame(8'h00, 8'h00, 8'h00, 16'h0000, 8'd1, 1'b1, 99, 1'b0);
    send_random_frame(8'd4, 1'b0, 2, 1'b0);
    send_ticks(TIMEOUT_RESET);
    send_ticks(1);

    timeout_plan = '{8'd0, 8'd1, 8'd20, 8'd3, 8'($urandom_range(12, 2))};
    foreach (timeout_plan[i]) begin
      settle();
      write_timeout(timeout_plan[i]);
      calm = (i == 3);
      if (i == 1) squeeze_req = 1'b1;
      send_random_frame(pick_len(), 1'b0, $urandom_range(7, 1), 1'b1);
      flush_frame();
      if (i == 0 || i == 3) send_random_frame(8'($urandom_range(255, 32)), 1'b0, 40, 1'b0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        kind = $urandom_range(99, 0);
        if (kind < 55) begin
          send_random_frame(pick_len(), 1'b0, 99, 1'b1);
        end else if (kind < 66) begin
          send_random_frame(pick_len(), 1'b1, 99, 1'b1);
        end else if (kind < 69) begin
          send_random_frame(8'($urandom_range(255, 32)), 1'b0, 40, 1'b0);
        end else if (kind < 80) begin
          send_random_frame(8'd31, 1'b0, $urandom_range(38, 1), 1'b1);
          flush_frame();
        end else if (kind < 90) begin
          repeat ($urandom_range(6, 1)) send_item(1'($urandom), 8'($urandom));
          flush_frame();
        end else begin
          send_ticks($urandom_range(3, 1));
        end
      end
      calm = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d input transfers (%0d frame bytes), checked %0d result transfers",
             items_sent, bytes_sent, results_seen);
    $display("Timeout settings 5, 0, 1, 20, 3 and %0d; good, bad-sum, stale and full frames",
             timeout_plan[4]);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### register_frame_receiver_unit.f
hw/rtl/rfr_pkg.sv
hw/rtl/rfr_frame_mem.sv
hw/rtl/register_frame_receiver_unit.sv
verif/rfr_frame_checker.sv
verif/tb.sv
